// ===== rtl/bct_pkg.sv =====
package bct_pkg;

   // Default sizes of the count table.
   localparam int DefaultRows      = 256;
   localparam int DefaultCols      = 64;
   localparam int DefaultValueBits = 64;

   // Fixed field widths.
   localparam int OpW    = 2;
   localparam int RowW   = 8;
   localparam int ColW   = 6;
   localparam int CountW = 9;
   localparam int PartW  = 8;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 8;

   // Operation codes.
   localparam logic [OpW-1:0] OP_BUILD  = 2'd0;
   localparam logic [OpW-1:0] OP_READ   = 2'd1;
   localparam logic [OpW-1:0] OP_WINDOW = 2'd2;

   // Register indexes.
   localparam logic [CsrIdxW-1:0] CSR_LAST_ROW = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_LAST_COL = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_MAX_PART = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_RANGE     = 2'd1,
      STATUS_NOT_BUILT = 2'd2
   } status_type;

endpackage

// ===== rtl/bct_req_if.sv =====
interface bct_req_if
   import bct_pkg::*;
   ();

   logic              valid;
   logic              ready;
   logic [OpW-1:0]    operation;
   logic [RowW-1:0]   row;
   logic [ColW-1:0]   col;
   logic [CountW-1:0] term_count;

   modport source (output valid, output operation, output row, output col,
                   output term_count, input ready);
   modport sink   (input valid, input operation, input row, input col,
                   input term_count, output ready);

endinterface

// ===== rtl/bct_rsp_if.sv =====
interface bct_rsp_if
   import bct_pkg::*;
   #(parameter int VALUE_BITS = DefaultValueBits)
   ();

   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic [1:0]            status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);

endinterface

// ===== rtl/bounded_composition_table.sv =====
// Bounded composition count table.
// A build command fills entry F(r,c), the number of ways to write r as an
// ordered sum of c parts in 0..max_part, for every r up to last_row and c up
// to last_col, all modulo 2^VALUE_BITS. An entry read returns F(row,col); a
// window read returns the sum of term_count entries going down from row in col.
// Commands arrive on the req_chan channel and every command produces exactly
// one transfer on rsp_chan with a value and a status (ok, out of range, or
// table not built). The user must write the registers last_row, last_col and
// max_part on the csr_ port only while the block is idle, which the block does
// not enforce; a build latches them. The table lives in one synchronous memory
// with a write port and two read ports. A build visits each entry by reading
// F(r-1,c) and F(r-max_part-1,c-1) in S_BUILD_RD, then writing it in
// S_BUILD_WR. Memory reads are registered, and a single sequencer serves
// every command.
// A new command is taken whenever the sequencer is idle, even while a result
// still waits in the output register; a stalled receiver holds the result
// there and the next command waits at its end. Reset is synchronous: the table
// is marked not built, registers return to their defaults, and no memory
// clearing is needed because reads only reach entries that a build wrote.
module bounded_composition_table
   import bct_pkg::*;
   #(
      parameter int ROWS       = DefaultRows,
      parameter int COLS       = DefaultCols,
      parameter int VALUE_BITS = DefaultValueBits
   )
   (
      input  logic                clock,
      input  logic                reset,
      bct_req_if.sink             req_chan,
      bct_rsp_if.source           rsp_chan,
      input  logic                csr_we,
      input  logic [CsrIdxW-1:0]  csr_index,
      input  logic [CsrDataW-1:0] csr_wdata
   );

   localparam int Depth    = ROWS * COLS;
   localparam int AddrW    = $clog2(Depth);
   localparam int RowLimit = (ROWS - 1 < 255) ? ROWS - 1 : 255;
   localparam int ColLimit = (COLS - 1 < 63) ? COLS - 1 : 63;
   localparam logic [RowW-1:0] ROW_LIMIT = RowW'(RowLimit);
   localparam logic [ColW-1:0] COL_LIMIT = ColW'(ColLimit);

   typedef enum logic [2:0] {
      S_IDLE,
      S_BUILD_RD,
      S_BUILD_WR,
      S_READ,
      S_WINDOW,
      S_DONE
   } state_type;

   function automatic logic [AddrW-1:0] cell_addr(input logic [RowW-1:0] r,
                                                  input logic [ColW-1:0] c);
      return AddrW'(int'(r) * COLS + int'(c));
   endfunction

   // Configuration registers.
   logic [RowW-1:0]  last_row_ff;
   logic [ColW-1:0]  last_col_ff;
   logic [PartW-1:0] max_part_ff;

   // Bounds latched by the most recent build.
   logic [RowW-1:0]  built_row_ff;
   logic [ColW-1:0]  built_col_ff;
   logic [PartW-1:0] built_part_ff;
   logic             table_ready_ff;

   state_type        state_ff;
   logic [RowW-1:0]  cur_row_ff;
   logic [ColW-1:0]  cur_col_ff;
   logic [CountW-1:0] win_left_ff;
   logic             pend_ff;
   logic [VALUE_BITS-1:0] acc_ff;
   logic [VALUE_BITS-1:0] prev_ff;
   logic [VALUE_BITS-1:0] res_value_ff;
   status_type       res_status_ff;
   logic             rsp_valid_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   status_type       rsp_status_ff;

   // The table and its registered read ports.
   logic [VALUE_BITS-1:0] mem [Depth];
   logic [VALUE_BITS-1:0] rd_a_ff;
   logic [VALUE_BITS-1:0] rd_b_ff;

   logic                  rd_en_a, rd_en_b, wr_en;
   logic [AddrW-1:0]      addr_a, addr_b, wr_addr;
   logic [VALUE_BITS-1:0] build_value;

   logic                  req_fire;
   status_type            req_status;
   logic [CountW-1:0]     win_limit;
   logic [CountW-1:0]     sub_row_wide;
   logic                  sub_ok;
   logic                  out_free;

   assign req_fire      = req_chan.valid && (state_ff == S_IDLE);
   assign req_chan.ready = (state_ff == S_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.value  = rsp_value_ff;
   assign rsp_chan.status = rsp_status_ff;

   // A window may hold at most min(row, max_part)+1 terms.
   assign win_limit = ((req_chan.row < built_part_ff) ? CountW'(req_chan.row)
                                                      : CountW'(built_part_ff))
                      + CountW'(1);

   always_comb begin
      case (req_chan.operation)
         OP_BUILD: begin
            req_status = STATUS_OK;
         end
         OP_READ, OP_WINDOW: begin
            if (!table_ready_ff) begin
               req_status = STATUS_NOT_BUILT;
            end else if (req_chan.row > built_row_ff || req_chan.col > built_col_ff) begin
               req_status = STATUS_RANGE;
            end else if (req_chan.operation == OP_WINDOW &&
                         req_chan.term_count > win_limit) begin
               req_status = STATUS_RANGE;
            end else begin
               req_status = STATUS_OK;
            end
         end
         default: begin
            req_status = STATUS_RANGE;
         end
      endcase
   end

   // The subtracted term F(r-max_part-1, c-1) exists only once r > max_part.
   assign sub_row_wide = CountW'(cur_row_ff) - CountW'(built_part_ff) - CountW'(1);
   assign sub_ok = CountW'(cur_row_ff) >= CountW'(built_part_ff) + CountW'(1);

   always_comb begin
      if (cur_row_ff == '0) begin
         build_value = VALUE_BITS'(1);
      end else if (cur_col_ff == '0) begin
         build_value = '0;
      end else begin
         build_value = rd_a_ff + prev_ff - (sub_ok ? rd_b_ff : '0);
      end
   end

   // Memory port control.
   always_comb begin
      rd_en_a = 1'b0;
      rd_en_b = 1'b0;
      wr_en   = 1'b0;
      addr_a  = '0;
      addr_b  = '0;
      wr_addr = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_chan.operation == OP_READ && req_status == STATUS_OK) begin
               rd_en_a = 1'b1;
               addr_a  = cell_addr(req_chan.row, req_chan.col);
            end
         end
         S_BUILD_RD: begin
            if (cur_row_ff != '0 && cur_col_ff != '0) begin
               rd_en_a = 1'b1;
               addr_a  = cell_addr(cur_row_ff - RowW'(1), cur_col_ff);
               rd_en_b = sub_ok;
               addr_b  = cell_addr(sub_row_wide[RowW-1:0], cur_col_ff - ColW'(1));
            end
         end
         S_BUILD_WR: begin
            wr_en   = 1'b1;
            wr_addr = cell_addr(cur_row_ff, cur_col_ff);
         end
         S_WINDOW: begin
            rd_en_a = (win_left_ff != '0);
            addr_a  = cell_addr(cur_row_ff, cur_col_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en_a) begin
         rd_a_ff <= mem[addr_a];
      end
      if (rd_en_b) begin
         rd_b_ff <= mem[addr_b];
      end
      if (wr_en) begin
         mem[wr_addr] <= build_value;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_row_ff <= '0;
         last_col_ff <= '0;
         max_part_ff <= PartW'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_LAST_ROW: last_row_ff <= csr_wdata[RowW-1:0];
            CSR_LAST_COL: last_col_ff <= csr_wdata[ColW-1:0];
            CSR_MAX_PART: max_part_ff <= csr_wdata[PartW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         table_ready_ff <= 1'b0;
         built_row_ff   <= '0;
         built_col_ff   <= '0;
         built_part_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         pend_ff        <= 1'b0;
      end else begin
         if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  res_value_ff  <= '0;
                  res_status_ff <= req_status;
                  if (req_chan.operation == OP_BUILD) begin
                     built_row_ff  <= (last_row_ff > ROW_LIMIT) ? ROW_LIMIT : last_row_ff;
                     built_col_ff  <= (last_col_ff > COL_LIMIT) ? COL_LIMIT : last_col_ff;
                     built_part_ff <= max_part_ff;
                     cur_row_ff    <= '0;
                     cur_col_ff    <= '0;
                     state_ff      <= S_BUILD_RD;
                  end else if (req_status != STATUS_OK) begin
                     state_ff <= S_DONE;
                  end else if (req_chan.operation == OP_READ) begin
                     state_ff <= S_READ;
                  end else if (req_chan.term_count == '0) begin
                     state_ff <= S_DONE;
                  end else begin
                     cur_row_ff  <= req_chan.row;
                     cur_col_ff  <= req_chan.col;
                     win_left_ff <= req_chan.term_count;
                     acc_ff      <= '0;
                     pend_ff     <= 1'b0;
                     state_ff    <= S_WINDOW;
                  end
               end
            end
            S_BUILD_RD: begin
               state_ff <= S_BUILD_WR;
            end
            S_BUILD_WR: begin
               // The value just written is F(r,c-1) for the next column.
               prev_ff <= build_value;
               if (cur_col_ff == built_col_ff) begin
                  cur_col_ff <= '0;
                  if (cur_row_ff == built_row_ff) begin
                     table_ready_ff <= 1'b1;
                     state_ff       <= S_DONE;
                  end else begin
                     cur_row_ff <= cur_row_ff + RowW'(1);
                     state_ff   <= S_BUILD_RD;
                  end
               end else begin
                  cur_col_ff <= cur_col_ff + ColW'(1);
                  state_ff   <= S_BUILD_RD;
               end
            end
            S_READ: begin
               res_value_ff <= rd_a_ff;
               state_ff     <= S_DONE;
            end
            S_WINDOW: begin
               // One read issues per cycle while its data from the previous
               // cycle is added in.
               if (win_left_ff != '0) begin
                  cur_row_ff  <= cur_row_ff - RowW'(1);
                  win_left_ff <= win_left_ff - CountW'(1);
               end
               pend_ff <= (win_left_ff != '0);
               if (pend_ff) begin
                  acc_ff <= acc_ff + rd_a_ff;
               end
               if (win_left_ff == '0 && !pend_ff) begin
                  res_value_ff <= acc_ff;
                  state_ff     <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= res_value_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
